FILE: hdl/i2cbm_pkg.sv
// ----------------------------------------------------------------------------
// I2C bit-level master package
// Shared types, command codes and sequencer phases for the I2C bit-level
// master and its submodules.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

	// Widths fixed by the transaction fields and registers.
	localparam int TPU_W   = 16;
	localparam int LIMIT_W = 8;
	localparam int UNIT_W  = 3;

	// Configuration register indexes.
	localparam logic REG_TICKS_PER_US = 1'b0;
	localparam logic REG_ACK_TIMEOUT  = 1'b1;

	// Configuration reset values.
	localparam logic [TPU_W-1:0]   TPU_RESET   = 16'd100;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd250;

	// Delay lengths in microsecond units.
	localparam logic [UNIT_W-1:0] UNITS_ONE  = 3'd1;
	localparam logic [UNIT_W-1:0] UNITS_TWO  = 3'd2;
	localparam logic [UNIT_W-1:0] UNITS_FOUR = 3'd4;
	localparam logic [UNIT_W-1:0] UNITS_FIVE = 3'd5;

	// Number of bits in one byte transfer.
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WACK  = 3'd3,
		CMD_WRITE = 3'd4,
		CMD_READ  = 3'd5
	} cmd_code_t;

	typedef enum logic [4:0] {
		PH_IDLE    = 5'd0,
		PH_ST_A    = 5'd1,
		PH_ST_B    = 5'd2,
		PH_SP_A    = 5'd3,
		PH_SP_B    = 5'd4,
		PH_SP_C    = 5'd5,
		PH_WA_A    = 5'd6,
		PH_WA_POLL = 5'd7,
		PH_WR_A    = 5'd8,
		PH_WR_B    = 5'd9,
		PH_WR_C    = 5'd10,
		PH_WR_D    = 5'd11,
		PH_RD_A    = 5'd12,
		PH_RD_B    = 5'd13,
		PH_RD_C    = 5'd14,
		PH_AK_D    = 5'd15,
		PH_AK_E    = 5'd16,
		PH_AK_F    = 5'd17,
		PH_FIN     = 5'd18
	} phase_t;

	// One input tick.
	typedef struct packed {
		logic [2:0] command;
		logic [7:0] tx_byte;
		logic       ack_after_read;
		logic       sda_in;
	} in_item_t;

	// One result tick.
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_failed;
	} out_item_t;

	// Sequencer state apart from the delay counter.
	typedef struct packed {
		phase_t     phase;
		logic [7:0] poll_count;
		logic [3:0] bit_index;
		logic [7:0] shift_byte;
		logic       ack_choice;
		logic       fail_flag;
		logic       scl_level;
		logic       sda_level;
		logic       drive_enable;
		logic [7:0] rx_hold;
	} seq_state_t;

	localparam seq_state_t SEQ_RESET = '{
		phase:        PH_IDLE,
		poll_count:   8'd0,
		bit_index:    4'd0,
		shift_byte:   8'd0,
		ack_choice:   1'b0,
		fail_flag:    1'b0,
		scl_level:    1'b1,
		sda_level:    1'b1,
		drive_enable: 1'b1,
		rx_hold:      8'd0
	};

endpackage

FILE: hdl/i2c_bit_level_master.sv
// ----------------------------------------------------------------------------
// I2C bit-level master
// Tick-driven I2C master sequencer for start, stop, acknowledge wait, byte
// write and byte read.
// ----------------------------------------------------------------------------
// Every accepted transaction on the command channel is one timing tick and
// yields exactly one result transaction carrying the pin levels and status
// after that tick. The block takes one tick per clock cycle while res_ready
// does not stall the result register; a tick passes the input register,
// the combinational sequencer step and the result register. Commands are
// taken only while the sequencer is idle, and delays count in ticks,
// ticks_per_us per delay unit, saturated to DELAY_BITS bits.
module i2c_bit_level_master
	import i2cbm_pkg::*;
#(
	parameter int DELAY_BITS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  in_item_t           cmd,
	output logic               res_valid,
	input  logic               res_ready,
	output out_item_t          res,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [TPU_W-1:0]   cfg_data
);

	logic [TPU_W-1:0]      ticks_per_us_q;
	logic [LIMIT_W-1:0]    ack_limit_q;
	in_item_t              item_s1;
	logic                  valid_s1;
	seq_state_t            state_q;
	logic [DELAY_BITS-1:0] dly_q;
	seq_state_t            state_nxt;
	logic [DELAY_BITS-1:0] dly_nxt;
	out_item_t             step_res;
	out_item_t             res_q;
	logic                  res_valid_q;
	logic                  advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_us_q <= TPU_RESET;
			ack_limit_q    <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TICKS_PER_US: ticks_per_us_q <= cfg_data;
				REG_ACK_TIMEOUT:  ack_limit_q    <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// The step runs when a tick waits in the input register and the
	// result register is free or being emptied.
	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_valid && cmd_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			item_s1 <= cmd;
		end
	end

	i2cbm_step #(
		.DELAY_BITS(DELAY_BITS)
	) u_step (
		.item(item_s1),
		.st(state_q),
		.dly(dly_q),
		.ticks_per_us(ticks_per_us_q),
		.ack_timeout_limit(ack_limit_q),
		.st_nxt(state_nxt),
		.dly_nxt(dly_nxt),
		.result(step_res)
	);

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_RESET;
			dly_q   <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			dly_q   <= dly_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// An idle sequencer never holds a pending delay.
	a_idle_no_delay: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_IDLE) |-> (dly_q == '0))
		else $error("delay pending while sequencer idle");

	// The bit counter never runs past one byte.
	a_bit_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bit_index <= BITS_PER_BYTE)
		else $error("bit index beyond one byte");

	// A completing tick never reports the sequencer as still busy.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.done_res && res_q.busy_res))
		else $error("done and busy reported together");

	// An empty result register always leaves room for a new transaction.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> cmd_ready)
		else $error("command channel stalled with empty result register");

endmodule

FILE: hdl/i2cbm_delay.sv
// ----------------------------------------------------------------------------
// I2C bit-level master delay length
// Converts a delay in microsecond units into ticks, saturated to the width
// of the delay counter.
// ----------------------------------------------------------------------------
module i2cbm_delay
	import i2cbm_pkg::*;
#(
	parameter int DELAY_BITS = 20
) (
	input  logic [UNIT_W-1:0]     units,
	input  logic [TPU_W-1:0]      ticks_per_us,
	output logic [DELAY_BITS-1:0] ticks
);

	localparam int PROD_W = UNIT_W + TPU_W;
	localparam int WIDE_W = (PROD_W > DELAY_BITS) ? PROD_W : DELAY_BITS;

	logic [PROD_W-1:0] prod;
	logic [WIDE_W-1:0] prod_wide;
	logic [WIDE_W-1:0] cap;

	// Small multiply, then clamp to the largest count the counter holds.
	assign prod      = PROD_W'(units) * PROD_W'(ticks_per_us);
	assign prod_wide = WIDE_W'(prod);
	assign cap       = {WIDE_W{1'b1}} >> (WIDE_W - DELAY_BITS);
	assign ticks     = (prod_wide > cap) ? cap[DELAY_BITS-1:0] : prod_wide[DELAY_BITS-1:0];

endmodule

FILE: hdl/i2cbm_step.sv
// ----------------------------------------------------------------------------
// I2C bit-level master sequencer step
// Computes the next sequencer state and the result of one tick from the
// current state, the incoming tick and the configuration.
// ----------------------------------------------------------------------------
module i2cbm_step
	import i2cbm_pkg::*;
#(
	parameter int DELAY_BITS = 20
) (
	input  in_item_t              item,
	input  seq_state_t            st,
	input  logic [DELAY_BITS-1:0] dly,
	input  logic [TPU_W-1:0]      ticks_per_us,
	input  logic [LIMIT_W-1:0]    ack_timeout_limit,
	output seq_state_t            st_nxt,
	output logic [DELAY_BITS-1:0] dly_nxt,
	output out_item_t             result
);

	seq_state_t            nx;
	logic [DELAY_BITS-1:0] dly_ph;
	logic [DELAY_BITS-1:0] ticks;
	logic [UNIT_W-1:0]     units;
	logic [3:0]            bit_inc;
	logic                  load;
	logic                  clr;
	logic                  dec;
	logic                  done;
	logic                  cmd_ok;

	i2cbm_delay #(
		.DELAY_BITS(DELAY_BITS)
	) u_delay (
		.units(units),
		.ticks_per_us(ticks_per_us),
		.ticks(ticks)
	);

	// A command code is taken only when the sequencer is idle.
	assign cmd_ok = (st.phase == PH_IDLE) &&
		((item.command == CMD_START) || (item.command == CMD_STOP) ||
		 (item.command == CMD_WACK) || (item.command == CMD_WRITE) ||
		 (item.command == CMD_READ));

	assign bit_inc = st.bit_index + 4'd1;

	// Command load followed by one action or one delay tick.
	always_comb begin
		nx     = st;
		dly_ph = dly;
		load   = 1'b0;
		clr    = 1'b0;
		dec    = 1'b0;
		done   = 1'b0;
		units  = UNITS_ONE;

		if (cmd_ok) begin
			dly_ph = '0;
			case (item.command)
				CMD_START: nx.phase = PH_ST_A;
				CMD_STOP:  nx.phase = PH_SP_A;
				CMD_WACK:  nx.phase = PH_WA_A;
				CMD_WRITE: begin
					nx.phase      = PH_WR_A;
					nx.shift_byte = item.tx_byte;
				end
				CMD_READ: begin
					nx.phase      = PH_RD_A;
					nx.ack_choice = item.ack_after_read;
				end
				default: ;
			endcase
		end

		if (nx.phase != PH_IDLE) begin
			if (dly_ph != '0) begin
				dec = 1'b1;
			end else begin
				case (nx.phase)
					PH_ST_A: begin
						nx.sda_level    = 1'b1;
						nx.scl_level    = 1'b1;
						nx.drive_enable = 1'b1;
						load            = 1'b1;
						units           = UNITS_FOUR;
						nx.phase        = PH_ST_B;
					end
					PH_ST_B: begin
						nx.sda_level = 1'b0;
						load         = 1'b1;
						units        = UNITS_FOUR;
						nx.phase     = PH_FIN;
					end
					PH_SP_A: begin
						nx.drive_enable = 1'b1;
						nx.scl_level    = 1'b1;
						load            = 1'b1;
						units           = UNITS_FOUR;
						nx.phase        = PH_SP_B;
					end
					PH_SP_B: begin
						nx.sda_level = 1'b0;
						load         = 1'b1;
						units        = UNITS_FOUR;
						nx.phase     = PH_SP_C;
					end
					PH_SP_C: begin
						nx.sda_level = 1'b1;
						load         = 1'b1;
						units        = UNITS_FOUR;
						nx.phase     = PH_FIN;
					end
					PH_WA_A: begin
						nx.drive_enable = 1'b0;
						nx.scl_level    = 1'b1;
						nx.poll_count   = 8'd0;
						load            = 1'b1;
						units           = UNITS_ONE;
						nx.phase        = PH_WA_POLL;
					end
					PH_WA_POLL: begin
						if (!item.sda_in) begin
							nx.scl_level = 1'b0;
							nx.fail_flag = 1'b0;
							nx.phase     = PH_IDLE;
							done         = 1'b1;
						end else if (st.poll_count >= ack_timeout_limit) begin
							// Timeout: flag it and run the first stop action now.
							nx.fail_flag    = 1'b1;
							nx.drive_enable = 1'b1;
							nx.scl_level    = 1'b1;
							load            = 1'b1;
							units           = UNITS_FOUR;
							nx.phase        = PH_SP_B;
						end else begin
							nx.poll_count = st.poll_count + 8'd1;
						end
					end
					PH_WR_A: begin
						nx.drive_enable = 1'b1;
						nx.scl_level    = 1'b0;
						nx.bit_index    = 4'd0;
						clr             = 1'b1;
						nx.phase        = PH_WR_B;
					end
					PH_WR_B: begin
						nx.sda_level  = st.shift_byte[7];
						nx.shift_byte = {st.shift_byte[6:0], 1'b0};
						load          = 1'b1;
						units         = UNITS_FIVE;
						nx.phase      = PH_WR_C;
					end
					PH_WR_C: begin
						nx.scl_level = 1'b1;
						load         = 1'b1;
						units        = UNITS_FIVE;
						nx.phase     = PH_WR_D;
					end
					PH_WR_D: begin
						nx.scl_level = 1'b0;
						nx.bit_index = bit_inc;
						load         = 1'b1;
						units        = UNITS_FIVE;
						nx.phase     = (bit_inc < BITS_PER_BYTE) ? PH_WR_B : PH_FIN;
					end
					PH_RD_A: begin
						nx.drive_enable = 1'b0;
						nx.shift_byte   = 8'd0;
						nx.bit_index    = 4'd0;
						clr             = 1'b1;
						nx.phase        = PH_RD_B;
					end
					PH_RD_B: begin
						nx.scl_level = 1'b0;
						load         = 1'b1;
						units        = UNITS_FIVE;
						nx.phase     = PH_RD_C;
					end
					PH_RD_C: begin
						nx.scl_level  = 1'b1;
						nx.shift_byte = {st.shift_byte[6:0], item.sda_in};
						nx.bit_index  = bit_inc;
						load          = 1'b1;
						units         = UNITS_FIVE;
						nx.phase      = (bit_inc < BITS_PER_BYTE) ? PH_RD_B : PH_AK_D;
					end
					PH_AK_D: begin
						nx.scl_level    = 1'b0;
						nx.drive_enable = 1'b1;
						nx.sda_level    = !st.ack_choice;
						load            = 1'b1;
						units           = UNITS_TWO;
						nx.phase        = PH_AK_E;
					end
					PH_AK_E: begin
						nx.scl_level = 1'b1;
						load         = 1'b1;
						units        = UNITS_TWO;
						nx.phase     = PH_AK_F;
					end
					PH_AK_F: begin
						nx.scl_level = 1'b0;
						load         = st.ack_choice;
						clr          = !st.ack_choice;
						units        = UNITS_TWO;
						nx.rx_hold   = st.shift_byte;
						nx.phase     = PH_FIN;
					end
					PH_FIN: begin
						nx.phase = PH_IDLE;
						done     = 1'b1;
					end
					default: begin
						nx.phase = PH_IDLE;
					end
				endcase
			end
		end
	end

	// Delay counter update.
	assign dly_nxt = load ? ticks :
		(clr ? '0 : (dec ? dly_ph - DELAY_BITS'(1) : dly_ph));

	assign st_nxt = nx;

	// Pin levels and status after this tick.
	always_comb begin
		result.scl_out    = nx.scl_level;
		result.sda_out    = nx.sda_level;
		result.sda_drive  = nx.drive_enable;
		result.busy_res   = (nx.phase != PH_IDLE);
		result.done_res   = done;
		result.rx_byte    = nx.rx_hold;
		result.ack_failed = nx.fail_flag;
	end

endmodule
